// ----- sv/kvc_pkg.sv -----
`timescale 1ns / 1ps

package kvc_pkg;

    localparam int FUNC_W     = 2;
    localparam int LAYER_W    = 2;
    localparam int POS_W      = 8;
    localparam int HEAD_W     = 2;
    localparam int ELEM_W     = 6;
    localparam int PORT_W     = 32;
    localparam int STATUS_W   = 3;
    localparam int USED_W     = 9;

    localparam int LCOUNT_W   = 3;
    localparam int TCAP_W     = 9;
    localparam int HCOUNT_W   = 3;
    localparam int HSIZE_W    = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [LCOUNT_W-1:0] RST_LAYER_COUNT    = 3'd1;
    localparam logic [TCAP_W-1:0]   RST_TOKEN_CAPACITY = 9'd256;
    localparam logic [HCOUNT_W-1:0] RST_HEAD_COUNT     = 3'd1;
    localparam logic [HSIZE_W-1:0]  RST_HEAD_SIZE      = 7'd64;

    localparam int DEF_MAX_LAYERS    = 4;
    localparam int DEF_MAX_TOKENS    = 256;
    localparam int DEF_MAX_HEADS     = 4;
    localparam int DEF_MAX_HEAD_SIZE = 64;
    localparam int DEF_WORD_BITS     = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_STORE = 2'd0,
        FUNC_READ  = 2'd1,
        FUNC_CLEAR = 2'd2
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_LAYER = 3'd1,
        ST_BAD_POS   = 3'd2,
        ST_BAD_HEAD  = 3'd3,
        ST_BAD_ELEM  = 3'd4
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LAYER_COUNT    = 2'd0,
        CFG_TOKEN_CAPACITY = 2'd1,
        CFG_HEAD_COUNT     = 2'd2,
        CFG_HEAD_SIZE      = 2'd3
    } t_cfg_idx;

endpackage

// ----- sv/kvc_in_if.sv -----
`timescale 1ns / 1ps

interface kvc_in_if import kvc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [LAYER_W-1:0]  layer;
    logic [POS_W-1:0]    position;
    logic [HEAD_W-1:0]   head;
    logic [ELEM_W-1:0]   element;
    logic [PORT_W-1:0]   key_word;
    logic [PORT_W-1:0]   value_word;

    modport source (
        output valid, func, layer, position, head, element, key_word, value_word,
        input  ready
    );

    modport sink (
        input  valid, func, layer, position, head, element, key_word, value_word,
        output ready
    );
endinterface

// ----- sv/kvc_out_if.sv -----
`timescale 1ns / 1ps

interface kvc_out_if import kvc_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [PORT_W-1:0]   key_out;
    logic [PORT_W-1:0]   value_out;
    logic [USED_W-1:0]   tokens_used;

    modport source (
        output valid, status, key_out, value_out, tokens_used,
        input  ready
    );

    modport sink (
        input  valid, status, key_out, value_out, tokens_used,
        output ready
    );
endinterface

// ----- sv/kvc_mem.sv -----
`timescale 1ns / 1ps

module kvc_mem import kvc_pkg::*; #(
    parameter int DEPTH  = DEF_MAX_LAYERS * DEF_MAX_TOKENS * DEF_MAX_HEADS * DEF_MAX_HEAD_SIZE,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    parameter int DATA_W = 2 * DEF_WORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [DATA_W-1:0] i_wdata,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/kvc_sweep.sv -----
`timescale 1ns / 1ps

module kvc_sweep import kvc_pkg::*; #(
    parameter int DEPTH  = DEF_MAX_LAYERS * DEF_MAX_TOKENS * DEF_MAX_HEADS * DEF_MAX_HEAD_SIZE,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    output logic              o_busy,
    output logic [ADDR_W-1:0] o_addr
);

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    logic              r_busy;
    logic [ADDR_W-1:0] r_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_start) begin
            r_busy <= 1'b1;
            r_addr <= '0;
        end else if (r_busy) begin
            if (r_addr == LAST_ADDR) begin
                r_busy <= 1'b0;
            end
            r_addr <= r_addr + ADDR_W'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_addr = r_addr;

endmodule

// ----- sv/kv_cache_store.sv -----
`timescale 1ns / 1ps

// Key/value cache: each item stores or reads one key word and one value word at
// (layer*token_capacity + position)*(head_count*head_size) + head*head_size + element,
// or clears the whole cache. Store and read items flow at one item per cycle while the
// output is ready and no zeroing pass runs (decode register, then the output register
// and the registered read data of the single-port memory). A clear item, and reset,
// start a zeroing pass over the one memory port, one entry per cycle, over all
// MAX_LAYERS*MAX_TOKENS*MAX_HEADS*MAX_HEAD_SIZE entries (262144 at the defaults),
// during which no item is accepted; configuration writes are taken at any time but
// are meant for idle periods. Registers above their parameter saturate at it.
module kv_cache_store import kvc_pkg::*; #(
    parameter int MAX_LAYERS    = DEF_MAX_LAYERS,
    parameter int MAX_TOKENS    = DEF_MAX_TOKENS,
    parameter int MAX_HEADS     = DEF_MAX_HEADS,
    parameter int MAX_HEAD_SIZE = DEF_MAX_HEAD_SIZE,
    parameter int WORD_BITS     = DEF_WORD_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    kvc_in_if.sink                i_in,
    kvc_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DEPTH  = MAX_LAYERS * MAX_TOKENS * MAX_HEADS * MAX_HEAD_SIZE;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ROW_W  = $clog2(MAX_LAYERS * MAX_TOKENS + 1);
    localparam int KV_W   = $clog2(MAX_HEADS * MAX_HEAD_SIZE + 1);
    localparam int MEM_W  = 2 * WORD_BITS;

    logic [LCOUNT_W-1:0] r_layer_count;
    logic [TCAP_W-1:0]   r_token_capacity;
    logic [HCOUNT_W-1:0] r_head_count;
    logic [HSIZE_W-1:0]  r_head_size;
    logic [KV_W-1:0]     r_kv_dim;

    logic [LCOUNT_W-1:0] lc_eff;
    logic [TCAP_W-1:0]   tc_eff;
    logic [HCOUNT_W-1:0] hc_eff;
    logic [HSIZE_W-1:0]  hs_eff;

    logic                r_a_valid;
    logic [FUNC_W-1:0]   r_a_func;
    logic [STATUS_W-1:0] r_a_status;
    logic [ROW_W-1:0]    r_a_row;
    logic [KV_W-1:0]     r_a_hoff;
    logic [POS_W-1:0]    r_a_pos;
    logic [MEM_W-1:0]    r_a_data;

    logic                r_c_valid;
    logic [STATUS_W-1:0] r_c_status;
    logic                r_c_rd;
    logic [USED_W-1:0]   r_c_tokens;
    logic [USED_W-1:0]   r_used;
    logic [USED_W-1:0]   n_used;

    logic [STATUS_W-1:0] in_status;
    logic                advance;
    logic                in_fire;
    logic                a_fire;
    logic                a_ok;
    logic                a_store;
    logic                a_read;
    logic                a_clear;
    logic [ADDR_W-1:0]   a_addr;

    logic                sweep_busy;
    logic [ADDR_W-1:0]   sweep_addr;
    logic                mem_en;
    logic                mem_we;
    logic [ADDR_W-1:0]   mem_addr;
    logic [MEM_W-1:0]    mem_wdata;
    logic [MEM_W-1:0]    mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_count    <= RST_LAYER_COUNT;
            r_token_capacity <= RST_TOKEN_CAPACITY;
            r_head_count     <= RST_HEAD_COUNT;
            r_head_size      <= RST_HEAD_SIZE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LAYER_COUNT:    r_layer_count    <= LCOUNT_W'(i_cfg_data);
                CFG_TOKEN_CAPACITY: r_token_capacity <= TCAP_W'(i_cfg_data);
                CFG_HEAD_COUNT:     r_head_count     <= HCOUNT_W'(i_cfg_data);
                CFG_HEAD_SIZE:      r_head_size      <= HSIZE_W'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign lc_eff = (int'(r_layer_count) > MAX_LAYERS) ? LCOUNT_W'(MAX_LAYERS) : r_layer_count;
    assign tc_eff = (int'(r_token_capacity) > MAX_TOKENS) ? TCAP_W'(MAX_TOKENS)
                                                           : r_token_capacity;
    assign hc_eff = (int'(r_head_count) > MAX_HEADS) ? HCOUNT_W'(MAX_HEADS) : r_head_count;
    assign hs_eff = (int'(r_head_size) > MAX_HEAD_SIZE) ? HSIZE_W'(MAX_HEAD_SIZE) : r_head_size;

    always_ff @(posedge i_clk) begin
        r_kv_dim <= KV_W'(10'(hc_eff) * 10'(hs_eff));
    end

    always_comb begin
        in_status = ST_OK;
        if (i_in.func == FUNC_STORE || i_in.func == FUNC_READ) begin
            if (LCOUNT_W'(i_in.layer) >= lc_eff) begin
                in_status = ST_BAD_LAYER;
            end else if (TCAP_W'(i_in.position) >= tc_eff) begin
                in_status = ST_BAD_POS;
            end else if (HCOUNT_W'(i_in.head) >= hc_eff) begin
                in_status = ST_BAD_HEAD;
            end else if (HSIZE_W'(i_in.element) >= hs_eff) begin
                in_status = ST_BAD_ELEM;
            end
        end
    end

    assign advance = !r_c_valid || o_out.ready;
    assign a_clear = r_a_func == FUNC_CLEAR;
    assign i_in.ready = advance && !sweep_busy && !(r_a_valid && a_clear);
    assign in_fire = i_in.valid && i_in.ready;
    assign a_fire  = r_a_valid && advance;
    assign a_ok    = r_a_status == ST_OK;
    assign a_store = a_ok && r_a_func == FUNC_STORE;
    assign a_read  = a_ok && r_a_func == FUNC_READ;
    assign a_addr  = ADDR_W'(ADDR_W'(r_a_row) * ADDR_W'(r_kv_dim)) + ADDR_W'(r_a_hoff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_fire) begin
            r_a_valid <= 1'b1;
        end else if (a_fire) begin
            r_a_valid <= 1'b0;
        end
        if (in_fire) begin
            r_a_func   <= i_in.func;
            r_a_status <= in_status;
            r_a_row    <= ROW_W'(ROW_W'(i_in.layer) * ROW_W'(tc_eff)) + ROW_W'(i_in.position);
            r_a_hoff   <= KV_W'(KV_W'(i_in.head) * KV_W'(hs_eff)) + KV_W'(i_in.element);
            r_a_pos    <= i_in.position;
            r_a_data   <= {WORD_BITS'(i_in.key_word), WORD_BITS'(i_in.value_word)};
        end
    end

    always_comb begin
        n_used = r_used;
        if (a_fire) begin
            if (a_clear) begin
                n_used = '0;
            end else if (a_store && (USED_W'(r_a_pos) + USED_W'(1)) > r_used) begin
                n_used = USED_W'(r_a_pos) + USED_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used    <= '0;
            r_c_valid <= 1'b0;
        end else begin
            r_used <= n_used;
            if (advance) begin
                r_c_valid <= r_a_valid;
            end
        end
        if (a_fire) begin
            r_c_status <= r_a_status;
            r_c_rd     <= a_read;
            r_c_tokens <= n_used;
        end
    end

    kvc_sweep #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_sweep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (a_fire && a_clear),
        .o_busy  (sweep_busy),
        .o_addr  (sweep_addr)
    );

    assign mem_en    = sweep_busy || (a_fire && (a_store || a_read));
    assign mem_we    = sweep_busy || a_store;
    assign mem_addr  = sweep_busy ? sweep_addr : a_addr;
    assign mem_wdata = sweep_busy ? '0 : r_a_data;

    kvc_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (MEM_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_en    (mem_en),
        .i_we    (mem_we),
        .i_addr  (mem_addr),
        .i_wdata (mem_wdata),
        .o_rdata (mem_rdata)
    );

    assign o_out.valid       = r_c_valid;
    assign o_out.status      = r_c_status;
    assign o_out.key_out     = r_c_rd ? PORT_W'(mem_rdata[MEM_W-1 -: WORD_BITS]) : '0;
    assign o_out.value_out   = r_c_rd ? PORT_W'(mem_rdata[WORD_BITS-1:0]) : '0;
    assign o_out.tokens_used = r_c_tokens;

    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_busy |-> !i_in.ready)
        else $error("item accepted during zeroing pass");

    a_no_access_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_busy |-> !a_fire)
        else $error("item reached memory during zeroing pass");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && a_clear) |=> (r_c_tokens == '0 && r_c_status == ST_OK && !r_c_rd
                                 && sweep_busy))
        else $error("clear item result or pass start wrong");

    a_store_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && a_store) |=> (r_used > USED_W'($past(r_a_pos))))
        else $error("used count below stored position");

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top import kvc_pkg::*; ();

    localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
    localparam int IDLE_PCT   = 24;
    localparam int MAX_SHOWN  = 20;
    localparam int RECENT_MAX = 64;

    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [LAYER_W-1:0] layer;
        logic [POS_W-1:0]   position;
        logic [HEAD_W-1:0]  head;
        logic [ELEM_W-1:0]  element;
        logic [PORT_W-1:0]  key_word;
        logic [PORT_W-1:0]  value_word;
    } t_access;

    typedef struct packed {
        t_status           status;
        logic [PORT_W-1:0] key_out;
        logic [PORT_W-1:0] value_out;
        logic [USED_W-1:0] tokens_used;
    } t_outcome;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    kvc_in_if  in_ch ();
    kvc_out_if out_ch ();

    kv_cache_store uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    t_access  access_q[$];
    t_outcome outcome_q[$];
    t_access  recent_q[$];
    t_access  in_flight;

    logic [PORT_W-1:0] key_mem[int];
    logic [PORT_W-1:0] value_mem[int];
    logic [USED_W-1:0] used_count;

    logic [LCOUNT_W-1:0] cfg_layers;
    logic [TCAP_W-1:0]   cfg_tokens;
    logic [HCOUNT_W-1:0] cfg_heads;
    logic [HSIZE_W-1:0]  cfg_hsize;

    bit steady;
    int mismatches;
    int n_checked;
    int n_accepted;
    int n_stores;
    int n_reads;
    int n_rejected;
    int n_clears;
    int n_spare;
    int n_settings;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int clamp_reg(int v, int top);
        return (v > top) ? top : v;
    endfunction

    function automatic t_outcome predict_access(t_access a);
        int lc;
        int tc;
        int hc;
        int hs;
        int addr;
        t_outcome r;
        lc = clamp_reg(int'(cfg_layers), DEF_MAX_LAYERS);
        tc = clamp_reg(int'(cfg_tokens), DEF_MAX_TOKENS);
        hc = clamp_reg(int'(cfg_heads), DEF_MAX_HEADS);
        hs = clamp_reg(int'(cfg_hsize), DEF_MAX_HEAD_SIZE);
        r.status    = ST_OK;
        r.key_out   = '0;
        r.value_out = '0;
        case (a.func)
            FUNC_CLEAR: begin
                key_mem.delete();
                value_mem.delete();
                used_count = '0;
                n_clears++;
            end
            FUNC_STORE, FUNC_READ: begin
                if (a.layer >= lc) begin
                    r.status = ST_BAD_LAYER;
                end else if (a.position >= tc) begin
                    r.status = ST_BAD_POS;
                end else if (a.head >= hc) begin
                    r.status = ST_BAD_HEAD;
                end else if (a.element >= hs) begin
                    r.status = ST_BAD_ELEM;
                end else begin
                    addr = (a.layer * tc + a.position) * (hc * hs) + a.head * hs + a.element;
                    if (a.func == FUNC_STORE) begin
                        key_mem[addr]   = a.key_word;
                        value_mem[addr] = a.value_word;
                        if (int'(a.position) + 1 > int'(used_count))
                            used_count = USED_W'(a.position) + USED_W'(1);
                        n_stores++;
                    end else begin
                        if (key_mem.exists(addr)) begin
                            r.key_out   = key_mem[addr];
                            r.value_out = value_mem[addr];
                        end
                        n_reads++;
                    end
                end
                if (r.status != ST_OK)
                    n_rejected++;
            end
            default: begin
                n_spare++;
            end
        endcase
        r.tokens_used = used_count;
        return r;
    endfunction

    function automatic t_access make_access(logic [FUNC_W-1:0] f, int layer, int position,
                                            int head, int element,
                                            logic [PORT_W-1:0] k, logic [PORT_W-1:0] v);
        t_access a;
        a.func       = f;
        a.layer      = LAYER_W'(layer);
        a.position   = POS_W'(position);
        a.head       = HEAD_W'(head);
        a.element    = ELEM_W'(element);
        a.key_word   = k;
        a.value_word = v;
        return a;
    endfunction

    function automatic logic [PORT_W-1:0] random_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_access random_access();
        int lc;
        int tc;
        int hc;
        int hs;
        int pick;
        t_access a;
        lc = clamp_reg(int'(cfg_layers), DEF_MAX_LAYERS);
        tc = clamp_reg(int'(cfg_tokens), DEF_MAX_TOKENS);
        hc = clamp_reg(int'(cfg_heads), DEF_MAX_HEADS);
        hs = clamp_reg(int'(cfg_hsize), DEF_MAX_HEAD_SIZE);
        pick = $urandom_range(0, 99);
        a.key_word   = random_word();
        a.value_word = random_word();
        a.func       = ($urandom_range(0, 1) == 0) ? FUNC_STORE : FUNC_READ;
        if (pick < 2) begin
            a.func = FUNC_SPARE;
        end
        if (pick < 12 || lc == 0 || tc == 0 || hc == 0 || hs == 0) begin
            a.layer    = LAYER_W'($urandom);
            a.position = POS_W'($urandom);
            a.head     = HEAD_W'($urandom);
            a.element  = ELEM_W'($urandom);
        end else if (a.func == FUNC_READ && recent_q.size() > 0 &&
                     $urandom_range(0, 9) < 7) begin
            a = recent_q[$urandom_range(0, recent_q.size() - 1)];
            a.func = FUNC_READ;
        end else begin
            a.layer    = LAYER_W'($urandom_range(0, lc - 1));
            a.position = POS_W'($urandom_range(0, tc - 1));
            a.head     = HEAD_W'($urandom_range(0, hc - 1));
            a.element  = ELEM_W'($urandom_range(0, hs - 1));
            if (a.func == FUNC_STORE) begin
                recent_q.push_back(a);
                if (recent_q.size() > RECENT_MAX)
                    void'(recent_q.pop_front());
            end
        end
        return a;
    endfunction

    task automatic write_config(int lc, int tc, int hc, int hs);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_LAYER_COUNT;
        i_cfg_data <= CFG_DATA_W'(lc);
        cfg_layers = LCOUNT_W'(lc);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_TOKEN_CAPACITY;
        i_cfg_data <= CFG_DATA_W'(tc);
        cfg_tokens = TCAP_W'(tc);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEAD_COUNT;
        i_cfg_data <= CFG_DATA_W'(hc);
        cfg_heads = HCOUNT_W'(hc);
        @(posedge i_clk);
        i_cfg_idx  <= CFG_HEAD_SIZE;
        i_cfg_data <= CFG_DATA_W'(hs);
        cfg_hsize = HSIZE_W'(hs);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        recent_q.delete();
        n_settings++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        while (access_q.size() > 0 || in_ch.valid || outcome_q.size() > 0)
            @(negedge i_clk);
    endtask

    // driver: predict on acceptance, then advance or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                outcome_q.push_back(predict_access(in_flight));
                n_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (access_q.size() > 0 && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    in_flight = access_q.pop_front();
                    in_ch.valid      <= 1'b1;
                    in_ch.func       <= in_flight.func;
                    in_ch.layer      <= in_flight.layer;
                    in_ch.position   <= in_flight.position;
                    in_ch.head       <= in_flight.head;
                    in_ch.element    <= in_flight.element;
                    in_ch.key_word   <= in_flight.key_word;
                    in_ch.value_word <= in_flight.value_word;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor: compare each item against the oldest prediction
    always @(posedge i_clk) begin
        t_outcome seen;
        t_outcome want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            seen.status      = t_status'(out_ch.status);
            seen.key_out     = out_ch.key_out;
            seen.value_out   = out_ch.value_out;
            seen.tokens_used = out_ch.tokens_used;
            if (outcome_q.size() == 0) begin
                if (mismatches < MAX_SHOWN)
                    $display("%0t: unexpected item status=%0d key=%h value=%h used=%0d",
                             $time, seen.status, seen.key_out, seen.value_out,
                             seen.tokens_used);
                mismatches++;
            end else begin
                want = outcome_q.pop_front();
                n_checked++;
                if (seen !== want) begin
                    if (mismatches < MAX_SHOWN) begin
                        $display("%0t: expected status=%0d key=%h value=%h used=%0d,",
                                 $time, want.status, want.key_out, want.value_out,
                                 want.tokens_used);
                        $display("    got status=%0d key=%h value=%h used=%0d",
                                 seen.status, seen.key_out, seen.value_out,
                                 seen.tokens_used);
                    end
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #40_000_000;
        $display("kv_cache_store verification failed");
        $finish;
    end

    initial begin
        int lc;
        int tc;
        int hc;
        int hs;
        int n;
        i_cfg_we         <= 1'b0;
        i_cfg_idx        <= CFG_LAYER_COUNT;
        i_cfg_data       <= '0;
        i_rst_n          <= 1'b0;
        cfg_layers = RST_LAYER_COUNT;
        cfg_tokens = RST_TOKEN_CAPACITY;
        cfg_heads  = RST_HEAD_COUNT;
        cfg_hsize  = RST_HEAD_SIZE;
        used_count = '0;
        steady     = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_config(2, 100, 2, 32);
        access_q.push_back(make_access(FUNC_STORE, 0, 0, 0, 0, '0, '0));
        access_q.push_back(make_access(FUNC_STORE, 1, 99, 1, 31, '1, '1));
        access_q.push_back(make_access(FUNC_READ, 1, 99, 1, 31, '0, '0));
        access_q.push_back(make_access(FUNC_READ, 0, 0, 0, 0, '1, '1));
        access_q.push_back(make_access(FUNC_STORE, 0, 50, 1, 5, 32'h3f80_0000, 32'hbf80_0000));
        access_q.push_back(make_access(FUNC_STORE, 1, 10, 0, 7, 32'h8000_0000, 32'h7fff_ffff));
        access_q.push_back(make_access(FUNC_READ, 0, 50, 1, 5, '0, '0));
        access_q.push_back(make_access(FUNC_READ, 1, 98, 1, 31, '0, '0));
        access_q.push_back(make_access(FUNC_STORE, 2, 255, 3, 63, '1, '1));
        access_q.push_back(make_access(FUNC_READ, 3, 0, 0, 0, '0, '0));
        access_q.push_back(make_access(FUNC_STORE, 1, 100, 3, 63, '1, '1));
        access_q.push_back(make_access(FUNC_READ, 0, 255, 0, 0, '0, '0));
        access_q.push_back(make_access(FUNC_STORE, 1, 99, 2, 63, '1, '1));
        access_q.push_back(make_access(FUNC_READ, 0, 0, 3, 0, '0, '0));
        access_q.push_back(make_access(FUNC_STORE, 1, 99, 1, 32, '1, '1));
        access_q.push_back(make_access(FUNC_READ, 0, 0, 0, 63, '0, '0));
        access_q.push_back(make_access(FUNC_SPARE, 1, 99, 1, 31, '1, '1));
        access_q.push_back(make_access(FUNC_CLEAR, 3, 255, 3, 63, '1, '1));
        access_q.push_back(make_access(FUNC_READ, 1, 99, 1, 31, '0, '0));
        access_q.push_back(make_access(FUNC_STORE, 0, 20, 0, 1, 32'h1234_5678, 32'h9abc_def0));
        access_q.push_back(make_access(FUNC_READ, 0, 20, 0, 1, '0, '0));
        wait_idle();

        for (int p = 0; p < 8; p++) begin
            case (p)
                0: begin lc = 4; tc = 256; hc = 4; hs = 64; n = 250; end
                1: begin lc = 7; tc = 511; hc = 7; hs = 127; n = 200; steady = 1'b1; end
                2: begin lc = 1; tc = 1; hc = 1; hs = 1; n = 120; end
                3: begin lc = 0; tc = 0; hc = 0; hs = 0; n = 40; end
                7: begin lc = 1; tc = 256; hc = 1; hs = 64; n = 150; end
                default: begin
                    lc = $urandom_range(1, 4);
                    tc = $urandom_range(1, 256);
                    hc = $urandom_range(1, 4);
                    hs = $urandom_range(1, 64);
                    n  = 180;
                end
            endcase
            write_config(lc, tc, hc, hs);
            for (int i = 0; i < n; i++) begin
                if (p == 0 && i == n / 2)
                    access_q.push_back(make_access(FUNC_CLEAR, $urandom, $urandom, $urandom,
                                                   $urandom, $urandom, $urandom));
                access_q.push_back(random_access());
            end
            wait_idle();
            steady = 1'b0;
        end

        repeat (20) @(posedge i_clk);
        $display("Covered %0d items over %0d geometry settings: %0d stores, %0d reads,",
                 n_accepted, n_settings, n_stores, n_reads);
        $display("%0d rejected accesses, %0d clears, %0d spare codes; %0d results checked",
                 n_rejected, n_clears, n_spare, n_checked);
        if (mismatches == 0 && outcome_q.size() == 0) begin
            $display("kv_cache_store verification clean");
        end else begin
            $display("kv_cache_store verification failed");
        end
        $finish;
    end

endmodule
